// ===== rtl/assert_macros.svh =====
// assertion helpers, sampled on the rising edge of clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SEFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sefr_pkg.sv =====
package sefr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_NODE = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NODE     = 2'd0,
    KIND_LEN      = 2'd1,
    KIND_PAYLOAD  = 2'd2,
    KIND_CHECKSUM = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EVT_NONE     = 2'd0,
    EVT_ZERO_LEN = 2'd1,
    EVT_TIMEOUT  = 2'd2
  } evt_t;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_SYNC_CODE     = 2'd0;
  localparam logic [1:0] REG_ESCAPE_CODE   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0]  SYNC_CODE_RST     = 8'hE0;
  localparam logic [7:0]  ESCAPE_CODE_RST   = 8'hD0;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd2;

  typedef struct packed {
    evt_t  event_code;
    logic  checksum_good;
    kind_t byte_kind;
  } res_user_t;

endpackage

// ===== rtl/sync_escape_frame_receiver.sv =====
// Sync/escape frame receiver. Each input word is either a raw serial byte
// (in_tuser = 0) or one timer tick (in_tuser = 1). Bytes are dropped until
// the sync code is seen; inside a frame the escape code is removed and the
// following byte is delivered plus one. The decoded stream is node, length L
// and L more bytes, the last being the checksum, which is checked against the
// 8-bit sum of node, length and payload. A zero length and an idle timeout
// are reported on out_tuser and send the receiver back to hunting. A word
// yields zero or one output word. One word is accepted every cycle unless
// out_tready backpressure on the result register holds the flow, which is the
// only thing that can; each word is registered in the input register, and its
// result is then loaded into the result register, from which it is taken.
module sync_escape_frame_receiver
  import sefr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  input  logic [0:0]  in_tuser,     // [0] operation

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] data_byte
  output logic        out_tlast,
  output logic [4:0]  out_tuser,    // [1:0] byte_kind, [2] checksum_good, [4:3] event_code

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "assert_macros.svh"

  // configuration
  logic [7:0]  sync_code_r;
  logic [7:0]  escape_code_r;
  logic [15:0] timeout_ticks_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_code_r     <= SYNC_CODE_RST;
      escape_code_r   <= ESCAPE_CODE_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SYNC_CODE:     sync_code_r     <= cfg_pwdata[7:0];
        REG_ESCAPE_CODE:   escape_code_r   <= cfg_pwdata[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SYNC_CODE:     cfg_prdata = {24'd0, sync_code_r};
      REG_ESCAPE_CODE:   cfg_prdata = {24'd0, escape_code_r};
      REG_TIMEOUT_TICKS: cfg_prdata = {16'd0, timeout_ticks_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // result register
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  res_user_t   out_user_r;

  // input register
  logic       in_valid_r;
  logic       in_tick_r;
  logic [7:0] in_byte_r;
  logic       advance;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready) begin
      in_tick_r <= in_tuser[0];
      in_byte_r <= in_tdata;
    end
  end

  // receiver state
  phase_t      phase_r, phase_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        armed_r, armed_nxt;

  logic        res_valid;
  logic [7:0]  res_data;
  logic        res_last;
  res_user_t   res_user;
  logic [7:0]  dec;
  logic        work;

  assign work = in_valid_r && advance;
  assign dec  = pend_r ? in_byte_r + 8'd1 : in_byte_r;

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    idle_nxt  = idle_r;
    armed_nxt = armed_r;
    res_valid = 1'b0;
    res_data  = 8'd0;
    res_last  = 1'b0;
    res_user  = '{event_code: EVT_NONE, checksum_good: 1'b0, byte_kind: KIND_NODE};

    if (work) begin
      if (in_tick_r) begin
        if (armed_r) begin
          if (idle_r >= timeout_ticks_r) begin
            phase_nxt = PH_HUNT;
            pend_nxt  = 1'b0;
            sum_nxt   = 8'd0;
            left_nxt  = 8'd0;
            armed_nxt = 1'b0;
            res_valid = 1'b1;
            res_user.event_code = EVT_TIMEOUT;
          end else begin
            idle_nxt = idle_r + 16'd1;
          end
        end
      end else begin
        idle_nxt  = 16'd0;
        armed_nxt = 1'b1;
        if (phase_r == PH_HUNT) begin
          if (in_byte_r == sync_code_r) begin
            phase_nxt = PH_NODE;
            pend_nxt  = 1'b0;
            sum_nxt   = 8'd0;
            left_nxt  = 8'd0;
          end
        end else if (in_byte_r == escape_code_r) begin
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          res_valid = 1'b1;
          res_data  = dec;
          unique case (phase_r)
            PH_NODE: begin
              sum_nxt   = dec;
              phase_nxt = PH_LEN;
              res_user.byte_kind = KIND_NODE;
            end
            PH_LEN: begin
              res_user.byte_kind = KIND_LEN;
              if (dec == 8'd0) begin
                phase_nxt = PH_HUNT;
                sum_nxt   = 8'd0;
                res_user.event_code = EVT_ZERO_LEN;
              end else begin
                sum_nxt   = sum_r + dec;
                left_nxt  = dec;
                phase_nxt = PH_BODY;
              end
            end
            default: begin
              if (left_r <= 8'd1) begin
                phase_nxt = PH_HUNT;
                sum_nxt   = 8'd0;
                left_nxt  = 8'd0;
                res_last  = 1'b1;
                res_user.byte_kind     = KIND_CHECKSUM;
                res_user.checksum_good = (dec == sum_r);
              end else begin
                sum_nxt  = sum_r + dec;
                left_nxt = left_r - 8'd1;
                res_user.byte_kind = KIND_PAYLOAD;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      pend_r      <= 1'b0;
      sum_r       <= 8'd0;
      left_r      <= 8'd0;
      idle_r      <= 16'd0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      sum_r   <= sum_nxt;
      left_r  <= left_nxt;
      idle_r  <= idle_nxt;
      armed_r <= armed_nxt;
      if (advance) begin
        out_valid_r <= res_valid;
      end
    end
    if (advance) begin
      out_data_r <= res_data;
      out_last_r <= res_last;
      out_user_r <= res_user;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // a stalled result freezes the receiver state
  `SEFR_ASSERT_NEXT(a_stall_holds_state, out_valid_r && !out_tready,
    $stable(phase_r) && $stable(sum_r) && $stable(left_r), "state moved during stall")
  // end of frame only on a checksum word
  `SEFR_ASSERT_NOW(a_last_is_checksum, out_valid_r && out_last_r,
    out_user_r.byte_kind == KIND_CHECKSUM && out_user_r.event_code == EVT_NONE,
    "tlast on a non-checksum word")
  // a good checksum flag only comes with tlast
  `SEFR_ASSERT_NOW(a_good_needs_last, out_valid_r && out_user_r.checksum_good,
    out_last_r, "checksum_good without tlast")
  // a timeout leaves the receiver hunting and disarmed
  `SEFR_ASSERT_NEXT(a_timeout_resets, work && res_valid && res_user.event_code == EVT_TIMEOUT,
    phase_r == PH_HUNT && !armed_r && !pend_r, "timeout did not reset receiver")

endmodule

// ===== tb/sv/sync_escape_frame_receiver_tb.sv =====
module sync_escape_frame_receiver_tb;
  import sefr_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_QUARTER, RDY_BURSTS} ready_mode_t;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
    logic       good;
    evt_t       evt;
  } decoded_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic [0:0]  in_tuser = 1'b0;    // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] data_byte
  logic        out_tlast;
  logic [4:0]  out_tuser;          // [1:0] byte_kind, [2] checksum_good, [4:3] event_code
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'h0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sync_escape_frame_receiver i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver-side copy of the block state and registers
  logic [7:0]  sync_c = SYNC_CODE_RST;
  logic [7:0]  esc_c = ESCAPE_CODE_RST;
  logic [15:0] tmo_ticks = TIMEOUT_TICKS_RST;
  phase_t      rx_phase = PH_HUNT;
  logic        esc_pend = 1'b0;
  logic [7:0]  run_sum = 8'h00;
  logic [7:0]  bytes_left_q = 8'h00;
  logic [15:0] idle_cnt = 16'h0;
  logic        armed = 1'b0;

  decoded_word_t expected_words[$];
  int mismatch_count = 0;
  int live_items = 0;
  bit gaps_on = 1'b1;
  int burst_left = 0;

  function automatic void decode_word(input logic op, input logic [7:0] raw);
    logic [7:0] d;
    decoded_word_t w;
    w = '{data: 8'h00, kind: KIND_NODE, last: 1'b0, good: 1'b0, evt: EVT_NONE};
    if (op == OP_TICK) begin
      if (!armed) return;
      live_items++;
      if (idle_cnt >= tmo_ticks) begin
        rx_phase = PH_HUNT;
        esc_pend = 1'b0;
        run_sum = 8'h00;
        bytes_left_q = 8'h00;
        armed = 1'b0;
        w.evt = EVT_TIMEOUT;
        expected_words.push_back(w);
      end else begin
        idle_cnt++;
      end
      return;
    end
    idle_cnt = 16'h0;
    armed = 1'b1;
    if (rx_phase == PH_HUNT) begin
      if (raw == sync_c) begin
        live_items++;
        rx_phase = PH_NODE;
        esc_pend = 1'b0;
        run_sum = 8'h00;
        bytes_left_q = 8'h00;
      end
      return;
    end
    live_items++;
    if (raw == esc_c) begin
      esc_pend = 1'b1;
      return;
    end
    d = esc_pend ? raw + 8'd1 : raw;
    esc_pend = 1'b0;
    w.data = d;
    case (rx_phase)
      PH_NODE: begin
        run_sum = d;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        w.kind = KIND_LEN;
        run_sum = run_sum + d;
        if (d == 8'h00) begin
          rx_phase = PH_HUNT;
          run_sum = 8'h00;
          w.evt = EVT_ZERO_LEN;
        end else begin
          bytes_left_q = d;
          rx_phase = PH_BODY;
        end
      end
      default: begin
        if (bytes_left_q <= 8'd1) begin
          w.kind = KIND_CHECKSUM;
          w.last = 1'b1;
          w.good = (d == run_sum);
          rx_phase = PH_HUNT;
          run_sum = 8'h00;
          bytes_left_q = 8'h00;
        end else begin
          w.kind = KIND_PAYLOAD;
          run_sum = run_sum + d;
          bytes_left_q = bytes_left_q - 8'd1;
        end
      end
    endcase
    expected_words.push_back(w);
  endfunction

  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    decode_word(op, b);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(OP_TICK, 8'($urandom));
  endtask

  // a decoded byte goes out raw or as escape plus (byte - 1)
  task automatic send_decoded(input logic [7:0] d);
    if (d == esc_c || ($urandom_range(0, 5) == 0 && d - 8'd1 != esc_c)) begin
      send_word(OP_BYTE, esc_c);
      if ($urandom_range(0, 9) == 0) send_word(OP_BYTE, esc_c);
      send_word(OP_BYTE, d - 8'd1);
    end else begin
      send_word(OP_BYTE, d);
    end
    // idle ticks that stay within the allowed silence
    if ($urandom_range(0, 5) == 0)
      send_ticks($urandom_range(1, (tmo_ticks < 4) ? tmo_ticks : 4));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_SYNC_CODE:   sync_c = val[7:0];
      REG_ESCAPE_CODE: esc_c = val[7:0];
      default:         tmo_ticks = val[15:0];
    endcase
  endtask

  task automatic set_codes(input logic [7:0] s, input logic [7:0] e, input logic [15:0] t);
    wait_drain();
    write_reg(REG_SYNC_CODE, {24'h0, s});
    write_reg(REG_ESCAPE_CODE, {24'h0, e});
    write_reg(REG_TIMEOUT_TICKS, {16'h0, t});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic send_frame(input bit truncate);
    logic [7:0] node;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] d;
    int r;
    int i;
    int stop;
    repeat ($urandom_range(0, 2)) begin
      d = 8'($urandom);
      if (d == sync_c) d = ~d;
      send_word(OP_BYTE, d);
    end
    send_word(OP_BYTE, sync_c);
    node = 8'($urandom);
    send_decoded(node);
    r = $urandom_range(0, 63);
    if (r == 0) len = 8'h00;
    else if (r == 1) len = 8'($urandom_range(200, 255));
    else if (r < 52) len = 8'($urandom_range(1, 6));
    else len = 8'($urandom_range(7, 30));
    send_decoded(len);
    if (len == 8'h00) return;
    sum = node + len;
    stop = truncate ? $urandom_range(0, len - 1) : len - 1;
    for (i = 0; i < stop; i++) begin
      d = 8'($urandom);
      sum = sum + d;
      send_decoded(d);
    end
    if (truncate) begin
      if (tmo_ticks <= 16) send_ticks(tmo_ticks + 1);
    end else if ($urandom_range(0, 7) == 0) begin
      send_decoded(sum + 8'($urandom_range(1, 255)));
    end else begin
      send_decoded(sum);
    end
  endtask

  task automatic test_random_traffic(input int target);
    int start;
    int r;
    start = live_items;
    while (live_items - start < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_frame(1'b0);
      end else if (r < 9) begin
        repeat ($urandom_range(1, 5)) send_word(1'($urandom), 8'($urandom));
      end else begin
        send_frame(1'b1);
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_directed_frames();
    logic [8:0] seq [22];
    seq = '{
      {OP_TICK, 8'h00},                                     // tick before any byte
      {OP_BYTE, 8'h00}, {OP_BYTE, 8'hE0},                   // noise, then sync
      {OP_BYTE, 8'hD0}, {OP_BYTE, 8'hD0}, {OP_BYTE, 8'hFF}, // double escape, wraps to 0
      {OP_BYTE, 8'h02}, {OP_BYTE, 8'hE0}, {OP_BYTE, 8'hE2}, // sync as payload, good sum
      {OP_BYTE, 8'hE0}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'h00}, // zero length
      {OP_BYTE, 8'hE0}, {OP_BYTE, 8'h7F}, {OP_BYTE, 8'h01},
      {OP_BYTE, 8'h00},                                     // bad checksum
      {OP_BYTE, 8'hE0}, {OP_BYTE, 8'h01},
      {OP_TICK, 8'hFF}, {OP_TICK, 8'h00}, {OP_TICK, 8'hA5}, // third tick times out
      {OP_TICK, 8'h5A}                                      // disarmed again
    };
    foreach (seq[i]) send_word(seq[i][8], seq[i][7:0]);
  endtask

  task automatic test_extreme_codes();
    set_codes(8'h00, 8'hFF, 16'd1);
    test_random_traffic(80);
    set_codes(8'hFF, 8'h00, 16'hFFFF);
    test_random_traffic(80);
  endtask

  task automatic test_random_codes();
    repeat (3) begin
      set_codes(8'($urandom), 8'($urandom),
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                : $urandom_range(1, 8)));
      test_random_traffic(50);
    end
  endtask

  task automatic test_drain_pause();
    set_codes(SYNC_CODE_RST, ESCAPE_CODE_RST, TIMEOUT_TICKS_RST);
    test_random_traffic(25);
    wait_drain();
    test_random_traffic(25);
  endtask

  // result side stalls in ready modes that are chosen at random
  ready_mode_t rdy_mode = RDY_ALWAYS;
  int rdy_hold = 0;
  logic [3:0] rdy_cnt = 4'h0;

  always @(posedge clk) begin
    if (rdy_hold == 0) begin
      rdy_mode <= ready_mode_t'($urandom_range(0, 3));
      rdy_hold <= $urandom_range(20, 120);
    end else begin
      rdy_hold <= rdy_hold - 1;
    end
    rdy_cnt <= rdy_cnt + 4'd1;
    case (rdy_mode)
      RDY_ALWAYS:  out_tready <= 1'b1;
      RDY_RANDOM:  out_tready <= 1'($urandom);
      RDY_QUARTER: out_tready <= (rdy_cnt[1:0] == 2'd0);
      default:     out_tready <= (rdy_cnt > 4'd9);
    endcase
  end

  decoded_word_t want;
  res_user_t got_user;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word: data_byte %0h tuser %0h", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        got_user = out_tuser;
        if (out_tdata !== want.data) begin
          $error("data_byte: expected %0h, actual %0h", want.data, out_tdata);
          mismatch_count++;
        end
        if (got_user.byte_kind !== want.kind) begin
          $error("byte_kind: expected %0d, actual %0d", want.kind, got_user.byte_kind);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_frame: expected %0d, actual %0d", want.last, out_tlast);
          mismatch_count++;
        end
        if (got_user.checksum_good !== want.good) begin
          $error("checksum_good: expected %0d, actual %0d", want.good, got_user.checksum_good);
          mismatch_count++;
        end
        if (got_user.event_code !== want.evt) begin
          $error("event_code: expected %0d, actual %0d", want.evt, got_user.event_code);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_extreme_codes();
    test_random_codes();
    test_drain_pause();
    wait_drain();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sync_escape_frame_receiver.f =====
+incdir+rtl
rtl/sefr_pkg.sv
rtl/sync_escape_frame_receiver.sv
tb/sv/sync_escape_frame_receiver_tb.sv
